[rtl/olte_pkg.sv]
package olte_pkg;

  localparam int WORD_W      = 32;
  localparam int POS_W       = 5;
  localparam int OP_W        = 3;
  localparam int CNT_OUT_W   = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Match bits examined per cycle by the find scan.
  localparam int SCAN_W = 8;
  localparam int LSB_W  = $clog2(SCAN_W);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_FIND   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_APPEND = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t            op;
    logic [POS_W-1:0]    pos;
    logic [WORD_W-1:0]   value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

[rtl/olte_cell.sv]
module olte_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                      clk,
  input  olte_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]             count,
  input  logic [olte_pkg::WORD_W-1:0] left_d,
  input  logic [olte_pkg::WORD_W-1:0] right_d,
  output logic [olte_pkg::WORD_W-1:0] data,
  output logic                      match
);
  import olte_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // Each cell decides from its own slot number whether it loads the new word,
  // takes the word of a neighbor, or holds.
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (IDX == int'(ctl.pos)) begin
          data_nxt = ctl.value;
        end else if (IDX > int'(ctl.pos)) begin
          data_nxt = left_d;
        end
      end
      CELL_APPEND: begin
        if (IDX == int'(count)) begin
          data_nxt = ctl.value;
        end
      end
      CELL_REMOVE: begin
        if (IDX >= int'(ctl.pos)) begin
          data_nxt = right_d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == ctl.value) && (IDX < int'(count));

endmodule

[rtl/ordered_list_table_engine_core.sv]
// Ordered list of signed 32-bit words held in a chain of CAPACITY cells, one
// word per cell. Each input transaction carries an operation, a position and
// a value, and produces exactly one result transaction with the outcome, the
// word read or removed, the position found, the length after the operation
// and an empty flag. For insert, append, remove, read and clear, the result
// register holds the outcome on the cycle after the input transaction is
// accepted, and a new input transaction can be accepted in the same cycle
// that the previous result is taken. Find compares all cells in the accept
// cycle, then scans the captured match bits eight cells per cycle from the
// lowest position up, stopping at the first hit, and loads the result once
// the scan is done and the result register is free.
// While a find scans, or while a result waits with out_tready low, in_tready
// stays low. There is no clearing pass after reset: only slots below the
// current length are ever read or matched. Positions reach only the first
// 32 slots; found_at and count report the low bits of their values.
module ordered_list_table_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, from bit 0 up: op[2:0], position[7:3], value[39:8]
  input  logic [olte_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, from bit 0 up: ok[0], word[32:1], found_at[37:33],
  // count[43:38], is_empty[44], zero fill[47:45]
  output logic [olte_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import olte_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int NCH  = (CAPACITY + SCAN_W - 1) / SCAN_W;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  // Input fields.
  op_t                 in_op;
  logic [POS_W-1:0]    in_pos;
  logic [WORD_W-1:0]   in_value;
  logic                accept;

  assign in_op    = op_t'(in_tdata[OP_W-1:0]);
  assign in_pos   = in_tdata[OP_W +: POS_W];
  assign in_value = in_tdata[OP_W + POS_W +: WORD_W];
  assign accept   = in_tvalid && in_tready;

  // Control and list length.
  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CHW-1:0]      chunk_r, chunk_nxt;
  logic [NCH*SCAN_W-1:0] match_r, match_nxt;

  // Result register.
  logic                out_tvalid_r, out_tvalid_nxt;
  logic                ok_r, ok_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [POS_W-1:0]    found_r, found_nxt;
  logic [CNT_OUT_W-1:0] cnt_r, cnt_nxt;
  logic                empty_r, empty_nxt;

  // Cell chain.
  cell_ctl_t           ctl;
  logic [WORD_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [WORD_W-1:0] left_d;
      logic [WORD_W-1:0] right_d;
      // The end cells see themselves where no neighbor exists; the shift
      // rules never pick those inputs in a way that matters.
      if (gi == 0) begin : g_first
        assign left_d = cell_data[gi];
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      olte_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .count   (count_r),
        .left_d  (left_d),
        .right_d (right_d),
        .data    (cell_data[gi]),
        .match   (cell_match[gi])
      );
    end
  endgenerate

  // Word at the requested position; only the slots a position can name.
  logic [WORD_W-1:0] rd_word;
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (in_pos == POS_W'(i)) begin
        rd_word = cell_data[i];
      end
    end
  end

  // Operations other than find, decided from the accepted transaction.
  logic                imm_ok;
  logic [WORD_W-1:0]   imm_word;
  logic [CW-1:0]       imm_count;
  cell_op_t            imm_cell_op;
  logic                pos_live;
  logic                has_room;

  assign pos_live = int'(in_pos) < int'(count_r);
  assign has_room = int'(count_r) < CAPACITY;

  always_comb begin
    imm_ok      = 1'b0;
    imm_word    = '0;
    imm_count   = count_r;
    imm_cell_op = CELL_HOLD;
    case (in_op)
      OP_INSERT: begin
        if (has_room && (int'(in_pos) <= int'(count_r)) && (int'(in_pos) < CAPACITY)) begin
          imm_ok      = 1'b1;
          imm_count   = count_r + CW'(1);
          imm_cell_op = CELL_INSERT;
        end
      end
      OP_APPEND: begin
        if (has_room) begin
          imm_ok      = 1'b1;
          imm_count   = count_r + CW'(1);
          imm_cell_op = CELL_APPEND;
        end
      end
      OP_REMOVE: begin
        if (pos_live) begin
          imm_ok      = 1'b1;
          imm_word    = rd_word;
          imm_count   = count_r - CW'(1);
          imm_cell_op = CELL_REMOVE;
        end
      end
      OP_READ: begin
        if (pos_live) begin
          imm_ok   = 1'b1;
          imm_word = rd_word;
        end
      end
      OP_CLEAR: begin
        imm_ok    = 1'b1;
        imm_count = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctl.op    = accept ? imm_cell_op : CELL_HOLD;
  assign ctl.pos   = in_pos;
  assign ctl.value = in_value;

  // Find scan over the captured match bits, one group of cells per cycle.
  logic [SCAN_W-1:0]   chunk_bits;
  logic                scan_hit;
  logic [LSB_W-1:0]    scan_lsb;
  logic                scan_done;
  logic [CHW+LSB_W+POS_W-1:0] scan_idx;

  assign chunk_bits = match_r[chunk_r*SCAN_W +: SCAN_W];
  assign scan_hit   = |chunk_bits;
  assign scan_done  = scan_hit || (chunk_r == CHW'(NCH - 1));
  assign scan_idx   = (CHW + LSB_W + POS_W)'({chunk_r, scan_lsb});

  always_comb begin
    scan_lsb = '0;
    for (int j = SCAN_W - 1; j >= 0; j--) begin
      if (chunk_bits[j]) begin
        scan_lsb = LSB_W'(j);
      end
    end
  end

  // Count reported on the result port.
  logic [CW+CNT_OUT_W-1:0] imm_cnt_ext;
  logic [CW+CNT_OUT_W-1:0] cur_cnt_ext;
  assign imm_cnt_ext = (CW + CNT_OUT_W)'(imm_count);
  assign cur_cnt_ext = (CW + CNT_OUT_W)'(count_r);

  logic out_free;
  logic load_imm;
  logic load_scan;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign load_imm  = accept && (in_op != OP_FIND);
  assign load_scan = (state_r == ST_SCAN) && scan_done && out_free;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    chunk_nxt      = chunk_r;
    match_nxt      = match_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ok_nxt         = ok_r;
    word_nxt       = word_r;
    found_nxt      = found_r;
    cnt_nxt        = cnt_r;
    empty_nxt      = empty_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_FIND)) begin
          match_nxt = (NCH * SCAN_W)'(cell_match);
          chunk_nxt = '0;
          state_nxt = ST_SCAN;
        end else if (load_imm) begin
          count_nxt      = imm_count;
          out_tvalid_nxt = 1'b1;
          ok_nxt         = imm_ok;
          word_nxt       = imm_word;
          found_nxt      = '0;
          cnt_nxt        = imm_cnt_ext[CNT_OUT_W-1:0];
          empty_nxt      = (imm_count == '0);
        end
      end
      ST_SCAN: begin
        if (load_scan) begin
          out_tvalid_nxt = 1'b1;
          ok_nxt         = scan_hit;
          word_nxt       = '0;
          found_nxt      = scan_hit ? scan_idx[POS_W-1:0] : '0;
          cnt_nxt        = cur_cnt_ext[CNT_OUT_W-1:0];
          empty_nxt      = (count_r == '0);
          state_nxt      = ST_IDLE;
        end else if (!scan_done) begin
          chunk_nxt = chunk_r + CHW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      chunk_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      chunk_r      <= chunk_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    ok_r    <= ok_nxt;
    word_r  <= word_nxt;
    found_r <= found_nxt;
    cnt_r   <= cnt_nxt;
    empty_r <= empty_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, empty_r, cnt_r, found_r, word_r, ok_r};

endmodule

[rtl/olte_checker.sv]
module olte_checker #(
  parameter int CAPACITY = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [olte_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import olte_pkg::*;

  // A result held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The empty flag agrees with the reported count.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44] == (out_tdata[43:38] == 6'd0)))
    else $error("empty flag disagrees with count");

  // A failed transaction carries no word and no position.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[32:1] == '0) && (out_tdata[37:33] == '0))
    else $error("rejected result carries data");

  // The list never reports more entries than it holds.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[43:38]) <= CAPACITY))
    else $error("count beyond capacity");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ordered_list_table_engine_core olte_checker #(.CAPACITY(CAPACITY)) u_olte_checker (.*);
